@@ rtl/k_subset_enumerator_unit_defines.svh @@
`ifndef K_SUBSET_ENUMERATOR_UNIT_DEFINES_SVH
`define K_SUBSET_ENUMERATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on i_clk while out of reset
`define KSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk while out of reset
`define KSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kse_pkg.sv @@
`timescale 1ns / 1ps

package kse_pkg;

    // field widths
    localparam int POS_W      = 6;
    localparam int NUM_POS    = 8;
    localparam int SET_W      = 7;
    localparam int SUB_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = 1'b1;

    // register reset values
    localparam logic [SET_W-1:0] SET_SIZE_RESET    = 7'd8;
    localparam logic [SUB_W-1:0] SUBSET_SIZE_RESET = 4'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic advance;
    } t_dp_cmd;

endpackage

@@ rtl/kse_datapath.sv @@
`timescale 1ns / 1ps

module kse_datapath import kse_pkg::*; #(
    parameter int MAX_K = 8,
    parameter int MAX_N = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]            i_cfg_data,
    input  t_dp_cmd                          i_cmd,
    output logic [NUM_POS-1:0][POS_W-1:0]    o_pos,
    output logic                             o_done_res
);

    localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam logic [SET_W-1:0] MAX_N_C = SET_W'(MAX_N);
    localparam logic [SUB_W-1:0] MAX_K_C = SUB_W'(MAX_K);
    localparam int CW = SET_W + 1;

    function automatic logic [SET_W-1:0] f_eff_n(input logic [SET_W-1:0] v);
        return (v > MAX_N_C) ? MAX_N_C : v;
    endfunction

    function automatic logic [SUB_W-1:0] f_eff_k(input logic [SUB_W-1:0] v);
        return (v > MAX_K_C) ? MAX_K_C : v;
    endfunction

    logic [SET_W-1:0]  r_set_size;
    logic [SUB_W-1:0]  r_subset_size;
    logic [POS_W-1:0]  r_positions [MAX_K];
    logic              r_exhausted;
    logic              r_found;
    logic [KW-1:0]     r_pick;
    logic [POS_W-1:0]  r_base;
    logic [POS_W-1:0]  r_pos [NUM_POS];
    logic              r_done;

    logic [SET_W-1:0]  n_set_size;
    logic [SUB_W-1:0]  n_subset_size;
    logic [SET_W-1:0]  w_n;
    logic [SUB_W-1:0]  w_k;
    logic              w_found;
    logic [KW-1:0]     w_pick;
    logic [POS_W-1:0]  w_base;
    logic [POS_W-1:0]  w_pos_ext [NUM_POS];

    assign w_n = f_eff_n(r_set_size);
    assign w_k = f_eff_k(r_subset_size);

    // pad the position list out to the output count
    for (genvar g = 0; g < NUM_POS; g++) begin : g_ext
        if (g < MAX_K) begin : g_used
            assign w_pos_ext[g] = r_positions[g];
        end else begin : g_unused
            assign w_pos_ext[g] = '0;
        end
    end

    // register write decode
    always_comb begin
        n_set_size    = r_set_size;
        n_subset_size = r_subset_size;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SET_SIZE:    n_set_size    = i_cfg_data[SET_W-1:0];
                REG_SUBSET_SIZE: n_subset_size = i_cfg_data[SUB_W-1:0];
                default: ;
            endcase
        end
    end

    // rightmost position still below its limit n-k+i
    always_comb begin
        w_found = 1'b0;
        w_pick  = '0;
        for (int i = 0; i < MAX_K; i++) begin
            if ((SUB_W'(i) < w_k) &&
                ((CW'(r_positions[i]) + CW'(w_k)) < (CW'(w_n) + CW'(i)))) begin
                w_found = 1'b1;
                w_pick  = KW'(i);
            end
        end
    end

    // refill base: position j gets base + j from the pick onward
    assign w_base = r_positions[w_pick] + POS_W'(1) - POS_W'(w_pick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size    <= SET_SIZE_RESET;
            r_subset_size <= SUBSET_SIZE_RESET;
            for (int i = 0; i < MAX_K; i++) begin
                r_positions[i] <= POS_W'(i);
            end
            r_exhausted <= SET_W'(f_eff_k(SUBSET_SIZE_RESET)) > f_eff_n(SET_SIZE_RESET);
            r_found     <= 1'b0;
            r_pick      <= '0;
            r_base      <= '0;
            r_done      <= 1'b0;
            for (int i = 0; i < NUM_POS; i++) begin
                r_pos[i] <= '0;
            end
        end else if (i_cfg_we) begin
            // register write restarts the enumeration
            r_set_size    <= n_set_size;
            r_subset_size <= n_subset_size;
            for (int i = 0; i < MAX_K; i++) begin
                r_positions[i] <= POS_W'(i);
            end
            r_exhausted <= SET_W'(f_eff_k(n_subset_size)) > f_eff_n(n_set_size);
            r_found     <= 1'b0;
        end else begin
            // capture the current combination and the search result
            if (i_cmd.capture) begin
                r_done <= r_exhausted;
                for (int i = 0; i < NUM_POS; i++) begin
                    r_pos[i] <= (!r_exhausted && (SUB_W'(i) < w_k)) ? w_pos_ext[i] : '0;
                end
                r_found <= w_found && !r_exhausted;
                r_pick  <= w_pick;
                r_base  <= w_base;
                if (!r_exhausted && !w_found) begin
                    r_exhausted <= 1'b1;
                end
            end
            // increment the picked position and refill to its right
            if (i_cmd.advance && r_found) begin
                for (int i = 0; i < MAX_K; i++) begin
                    if ((KW'(i) >= r_pick) && (SUB_W'(i) < w_k)) begin
                        r_positions[i] <= r_base + POS_W'(i);
                    end
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_POS; g++) begin : g_out
        assign o_pos[g] = r_pos[g];
    end
    assign o_done_res = r_done;

endmodule

@@ rtl/kse_controller.sv @@
`timescale 1ns / 1ps
`include "k_subset_enumerator_unit_defines.svh"

module kse_controller import kse_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  logic    i_request,
    output logic    o_req_ready,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADV,
        S_HOLD
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   r_valid;
    logic   w_req_acc;

    assign w_req_acc     = i_req_valid && r_ready;
    assign o_cmd.capture = w_req_acc && i_request;
    assign o_cmd.advance = (r_state == S_ADV);

    // request sequencing: search on accept, advance next cycle, hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_req_acc && i_request) begin
                        r_ready <= 1'b0;
                        r_valid <= 1'b1;
                        r_state <= S_ADV;
                    end else begin
                        r_ready <= 1'b1;
                    end
                end
                S_ADV: begin
                    if (i_res_ready) begin
                        r_valid <= 1'b0;
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (i_res_ready) begin
                        r_valid <= 1'b0;
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b0;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_req_ready = r_ready;
    assign o_res_valid = r_valid;

    // checks
    `KSE_ASSERT_NOW(a_no_overlap, o_res_valid, !o_req_ready, "request taken while result pending")
    `KSE_ASSERT_NOW(a_adv_after_cap, o_cmd.advance, $past(o_cmd.capture), "advance without capture")
    `KSE_ASSERT_NEXT(a_ready_after_res, o_res_valid && i_res_ready, o_req_ready, "not ready after result")

endmodule

@@ rtl/k_subset_enumerator_unit.sv @@
`timescale 1ns / 1ps
// latency: the result is valid on the cycle after the request is taken
// search, capture on accept; update in S_ADV; no new request until the result is taken
// a request with request low is taken, ready stays high and no result is given
// reset: synchronous active low; n = 8, k = 2, position i holds i, ready the cycle after release
// a register write restarts the enumeration and takes priority over a capture

module k_subset_enumerator_unit import kse_pkg::*; #(
    parameter int MAX_K = 8,
    parameter int MAX_N = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic                  i_request,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [POS_W-1:0]      o_pos0,
    output logic [POS_W-1:0]      o_pos1,
    output logic [POS_W-1:0]      o_pos2,
    output logic [POS_W-1:0]      o_pos3,
    output logic [POS_W-1:0]      o_pos4,
    output logic [POS_W-1:0]      o_pos5,
    output logic [POS_W-1:0]      o_pos6,
    output logic [POS_W-1:0]      o_pos7,
    output logic                  o_done_res
);

    t_dp_cmd                      w_cmd;
    logic [NUM_POS-1:0][POS_W-1:0] w_pos;

    // handshake control
    kse_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_request   (i_request),
        .o_req_ready (o_req_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_cmd       (w_cmd)
    );

    // positions, search and result registers
    kse_datapath #(
        .MAX_K (MAX_K),
        .MAX_N (MAX_N)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_pos      (w_pos),
        .o_done_res (o_done_res)
    );

    assign o_pos0 = w_pos[0];
    assign o_pos1 = w_pos[1];
    assign o_pos2 = w_pos[2];
    assign o_pos3 = w_pos[3];
    assign o_pos4 = w_pos[4];
    assign o_pos5 = w_pos[5];
    assign o_pos6 = w_pos[6];
    assign o_pos7 = w_pos[7];

endmodule
